// ===== sv/hrhp_pkg.sv =====
// Shared types and constants of the HTTP request head parser.
package hrhp_pkg;

	// Head size limit in bytes, end marker included
	localparam int MAX_HEAD_BYTES = 8192;

	localparam int OFS_W  = 13;
	localparam int SIZE_W = 14;
	localparam int IN_W   = 8;
	localparam int OUT_W  = 72;

	// Characters the request line cares about
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_QM  = 8'h3F;

	// Three bytes that precede the final LF of CR LF CR LF
	localparam logic [23:0] MARK_PREFIX = 24'h0D0A0D;

	typedef enum logic [2:0] {
		PH_METHOD,
		PH_GAP1,
		PH_URI,
		PH_GAP2,
		PH_VERSION,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_MALFORMED,
		ST_TOO_LONG
	} status_t;

	typedef struct packed {
		logic [OFS_W-1:0]  headers_start;
		logic [OFS_W-1:0]  version_start;
		logic [OFS_W-1:0]  query_start;
		logic [OFS_W-1:0]  uri_start;
		logic [SIZE_W-1:0] head_size;
		status_t           status;
	} head_result_t;

endpackage

// ===== sv/hrhp_in_reg.sv =====
// Input register that holds one request byte for the parser.
module hrhp_in_reg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [hrhp_pkg::IN_W-1:0] s_tdata,   // in_byte[7:0]
	input  logic                    take,
	output logic                    byte_valid_s1,
	output logic [hrhp_pkg::IN_W-1:0] byte_s1
);
	import hrhp_pkg::*;

	// Accept when empty or when the held word is consumed this cycle
	assign s_tready = !byte_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			byte_valid_s1 <= s_tvalid;
		end
	end

	// Load payload on accept
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

// ===== sv/hrhp_parser.sv =====
// Request line tracker, end marker detection and result formation.
module hrhp_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      byte_valid,
	input  logic [hrhp_pkg::IN_W-1:0] byte_in,
	input  logic                      out_free,
	output logic                      take,
	output logic                      res_load,
	output hrhp_pkg::head_result_t    res
);
	import hrhp_pkg::*;

	phase_t            phase_q, phase_d;
	logic              err_q, err_d;
	logic [OFS_W-1:0]  offset_q;
	logic [23:0]       recent_q;
	logic [OFS_W-1:0]  uri_q, uri_d;
	logic [OFS_W-1:0]  query_q, query_d;
	logic [OFS_W-1:0]  ver_q, ver_d;
	logic [OFS_W-1:0]  hdr_q, hdr_d;

	logic              is_stop, is_sp, is_qm;
	logic [OFS_W-1:0]  pos_inc;
	logic [SIZE_W-1:0] size;
	logic              end_mark, too_long, emit, line_ok;

	// Classify the byte and work out position values
	assign is_stop  = (byte_in == CH_NUL) || (byte_in == CH_LF) || (byte_in == CH_CR);
	assign is_sp    = (byte_in == CH_SP);
	assign is_qm    = (byte_in == CH_QM);
	assign pos_inc  = OFS_W'(offset_q + OFS_W'(1));
	assign size     = SIZE_W'({1'b0, offset_q} + SIZE_W'(1));
	assign end_mark = (recent_q == MARK_PREFIX) && (byte_in == CH_LF);
	assign too_long = size >= SIZE_W'(MAX_HEAD_BYTES);
	assign emit     = end_mark || too_long;

	// Consume the byte unless a result has nowhere to go
	assign take     = byte_valid && (!emit || out_free);
	assign res_load = take && emit;

	// Advance the request line phase
	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		uri_d   = uri_q;
		query_d = query_q;
		ver_d   = ver_q;
		hdr_d   = hdr_q;
		if (!err_q) begin
			unique case (phase_q)
				PH_METHOD: begin
					if (is_stop) begin
						err_d = 1'b1;
					end else if (is_sp) begin
						phase_d = PH_GAP1;
					end
				end
				PH_GAP1: begin
					if (is_stop) begin
						err_d = 1'b1;
					end else if (!is_sp) begin
						uri_d   = offset_q;
						phase_d = PH_URI;
						if (is_qm && query_q == '0) begin
							query_d = pos_inc;
						end
					end
				end
				PH_URI: begin
					if (is_sp) begin
						phase_d = PH_GAP2;
					end else if (is_stop) begin
						err_d = 1'b1;
					end else if (is_qm && query_q == '0) begin
						query_d = pos_inc;
					end
				end
				PH_GAP2: begin
					if (is_stop) begin
						err_d = 1'b1;
					end else if (!is_sp) begin
						ver_d   = offset_q;
						phase_d = PH_VERSION;
					end
				end
				PH_VERSION: begin
					if (is_sp || is_stop) begin
						hdr_d   = offset_q;
						phase_d = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Form the result word
	always_comb begin
		line_ok = !err_d;
		res     = '0;
		if (end_mark) begin
			res.status    = line_ok ? ST_OK : ST_MALFORMED;
			res.head_size = size;
			if (line_ok) begin
				res.uri_start     = uri_d;
				res.query_start   = query_d;
				res.version_start = ver_d;
				res.headers_start = hdr_d;
			end
		end else begin
			res.status    = ST_TOO_LONG;
			res.head_size = SIZE_W'(MAX_HEAD_BYTES);
		end
	end

	// Update state per byte; restart after every result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_METHOD;
			err_q    <= 1'b0;
			offset_q <= '0;
			recent_q <= '0;
			uri_q    <= '0;
			query_q  <= '0;
			ver_q    <= '0;
			hdr_q    <= '0;
		end else if (take) begin
			if (emit) begin
				phase_q  <= PH_METHOD;
				err_q    <= 1'b0;
				offset_q <= '0;
				recent_q <= '0;
				uri_q    <= '0;
				query_q  <= '0;
				ver_q    <= '0;
				hdr_q    <= '0;
			end else begin
				phase_q  <= phase_d;
				err_q    <= err_d;
				offset_q <= size[OFS_W-1:0];
				recent_q <= {recent_q[15:0], byte_in};
				uri_q    <= uri_d;
				query_q  <= query_d;
				ver_q    <= ver_d;
				hdr_q    <= hdr_d;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (offset_q == '0) && (recent_q == '0) && (phase_q == PH_METHOD))
		else $error("parser state not cleared after result");

	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !res_load |=> $stable(phase_q))
		else $error("phase moved on a malformed line");

	a_uri_set: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_URI || phase_q == PH_GAP2 || phase_q == PH_VERSION ||
		 phase_q == PH_DONE) |-> (uri_q != '0))
		else $error("URI phase reached without URI offset");

	a_query_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(query_q != '0) |-> (phase_q != PH_METHOD && phase_q != PH_GAP1))
		else $error("query offset set before URI");

endmodule

// ===== sv/hrhp_out_reg.sv =====
// Output register that holds one result word until the receiver takes it.
module hrhp_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       res_load,
	input  hrhp_pkg::head_result_t     res,
	output logic                       out_free,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [hrhp_pkg::OUT_W-1:0] m_tdata
);
	import hrhp_pkg::*;

	head_result_t res_q;

	// Slot is free when empty or being drained this cycle
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= res_load;
		end
	end

	// Hold payload until replaced
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	// Pad the packed result to whole bytes
	assign m_tdata = {(OUT_W - $bits(head_result_t))'(0), res_q};

endmodule

// ===== sv/http_request_head_parser.sv =====
// HTTP request head parser: offsets and status of each request head.
//
// Usage: request bytes enter on the slave stream, one byte per word in
// s_tdata. Each head closed by CR LF CR LF, or cut off at the size limit,
// yields one result word on the master stream with status, head size and
// the URI, query, version and header start offsets.
// Throughput: one byte per cycle unless a byte that completes a head waits
// on a held result. The byte parse, end marker check and state update are
// one combinational pass from the input register to the output register.
// Result path: the final byte of a head passes the input register, then the
// parser loads the result into the output register, which raises m_tvalid.
// Reset: arst_n clears the valid flags of both registers and all parser
// state; parsing starts at offset zero in the method phase. After each result
// the parser restarts the same way for the next head.
// Stall: a held result blocks only a byte that itself completes a head;
// other bytes keep flowing. s_tready drops once the input register holds
// such a byte while a result waits in the output register and m_tready is
// low.
module http_request_head_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], head_size[15:2], uri_start[28:16], query_start[41:29],
	// version_start[54:42], headers_start[67:55], zero pad[71:68]
	output logic [71:0] m_tdata
);
	import hrhp_pkg::*;

	logic         take;
	logic         byte_valid_s1;
	logic [7:0]   byte_s1;
	logic         out_free;
	logic         res_load;
	head_result_t res;

	hrhp_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.take          (take),
		.byte_valid_s1 (byte_valid_s1),
		.byte_s1       (byte_s1)
	);

	hrhp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid_s1),
		.byte_in    (byte_s1),
		.out_free   (out_free),
		.take       (take),
		.res_load   (res_load),
		.res        (res)
	);

	hrhp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// Stream testbench of the HTTP request head parser with a byte-level predictor.
module testbench;
	import hrhp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // in_byte[7:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status[1:0], head_size[15:2], uri_start[28:16], query_start[41:29],
	// version_start[54:42], headers_start[67:55], zero pad[71:68]
	logic [71:0] m_tdata;

	http_request_head_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Bytes waiting to be sent and head results waiting to come out
	logic [7:0]   byte_stream[$];
	head_result_t results_due[$];

	int mismatches   = 0;
	int results_seen = 0;

	// Predictor state of the current head
	logic [13:0]   p_ofs;
	logic [23:0]   p_tail;
	phase_t        p_phase;
	logic          p_err;
	logic [12:0]   p_uri;
	logic [13:0]   p_query;
	logic [12:0]   p_ver;
	logic [12:0]   p_hdr;

	// Handshake bookkeeping of both sides
	logic byte_taken = 1'b0;
	logic rx_took    = 1'b0;
	int   tx_gap_left  = 0;
	bit   tx_quiet     = 1'b0;
	int   rx_wait_left = 0;
	bit   rx_quiet     = 1'b0;
	int   stall_left   = 0;
	bit   held_off     = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Reset, released at a falling edge
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	task automatic head_reset();
		p_ofs   = '0;
		p_tail  = '0;
		p_phase = PH_METHOD;
		p_err   = 1'b0;
		p_uri   = '0;
		p_query = '0;
		p_ver   = '0;
		p_hdr   = '0;
	endtask

	// Advance the head state by one byte and queue any result it closes
	task automatic parse_byte(input logic [7:0] b);
		logic [13:0]  pos;
		logic [14:0]  size;
		logic         closes;
		logic         stop;
		head_result_t r;
		pos    = p_ofs;
		size   = {1'b0, pos} + 15'd1;
		closes = (p_tail == MARK_PREFIX) && (b == CH_LF);
		stop   = (b == CH_NUL) || (b == CH_LF) || (b == CH_CR);
		if (!p_err) begin
			case (p_phase)
				PH_METHOD: begin
					if (stop) p_err = 1'b1;
					else if (b == CH_SP) p_phase = PH_GAP1;
				end
				PH_GAP1: begin
					if (stop) begin
						p_err = 1'b1;
					end else if (b != CH_SP) begin
						// first URI byte may itself open the query
						p_uri   = pos[12:0];
						p_phase = PH_URI;
						if (b == CH_QM && p_query == '0) p_query = pos + 14'd1;
					end
				end
				PH_URI: begin
					if (b == CH_SP) p_phase = PH_GAP2;
					else if (stop) p_err = 1'b1;
					else if (b == CH_QM && p_query == '0) p_query = pos + 14'd1;
				end
				PH_GAP2: begin
					if (stop) begin
						p_err = 1'b1;
					end else if (b != CH_SP) begin
						p_ver   = pos[12:0];
						p_phase = PH_VERSION;
					end
				end
				PH_VERSION: begin
					if (b == CH_SP || stop) begin
						p_hdr   = pos[12:0];
						p_phase = PH_DONE;
					end
				end
				default: ;
			endcase
		end
		p_tail = {p_tail[15:0], b};

		if (closes) begin
			r.status        = p_err ? ST_MALFORMED : ST_OK;
			r.head_size     = size[13:0];
			r.uri_start     = p_err ? '0 : p_uri;
			r.query_start   = p_err ? '0 : p_query[12:0];
			r.version_start = p_err ? '0 : p_ver;
			r.headers_start = p_err ? '0 : p_hdr;
			results_due.push_back(r);
			head_reset();
		end else if (size >= MAX_HEAD_BYTES) begin
			r.status        = ST_TOO_LONG;
			r.head_size     = SIZE_W'(MAX_HEAD_BYTES);
			r.uri_start     = '0;
			r.query_start   = '0;
			r.version_start = '0;
			r.headers_start = '0;
			results_due.push_back(r);
			head_reset();
		end else begin
			p_ofs = size[13:0];
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatches < 100)
			$display("mismatch in %s: got %0d, want %0d", what, got, want);
		mismatches++;
	endtask

	// Stimulus helpers
	task automatic put_byte(input logic [7:0] b);
		byte_stream.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_stream.push_back(s[i]);
	endtask

	task automatic put_eol();
		byte_stream.push_back(CH_CR);
		byte_stream.push_back(CH_LF);
	endtask

	// Token byte: never a space, CR, LF or NUL
	function automatic logic [7:0] token_byte();
		int          r;
		logic [7:0]  b;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			b = 8'($urandom_range(8'h21, 8'h7E));
		end else if (r < 9) begin
			b = 8'($urandom_range(8'h80, 8'hFF));
		end else begin
			b = 8'($urandom_range(8'h01, 8'h1F));
			if (b == CH_LF || b == CH_CR) b = 8'h7F;
		end
		return b;
	endfunction

	function automatic logic [7:0] stop_byte();
		case ($urandom_range(0, 2))
			0: return CH_NUL;
			1: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	// Queue one random head; returns 1 when it ends in the blank line marker
	task automatic put_random_head(output bit closed);
		logic [7:0] line[$];
		logic [7:0] term;
		int         kind;
		int         n;
		kind   = $urandom_range(0, 9);
		closed = 1'b0;
		// noise: raw bytes of any value
		if (kind == 0) begin
			n = $urandom_range(1, 24);
			repeat (n) put_byte(8'($urandom_range(0, 255)));
			return;
		end
		n = $urandom_range(1, 6);
		repeat (n) line.push_back(token_byte());
		n = $urandom_range(1, 3);
		repeat (n) line.push_back(CH_SP);
		n = $urandom_range(1, 12);
		repeat (n) line.push_back(($urandom_range(0, 5) == 0) ? CH_QM : token_byte());
		n = $urandom_range(1, 3);
		repeat (n) line.push_back(CH_SP);
		n = $urandom_range(1, 8);
		repeat (n) line.push_back(token_byte());
		case ($urandom_range(0, 7))
			0: term = CH_SP;
			1: term = CH_NUL;
			2: term = CH_LF;
			default: term = CH_CR;
		endcase
		line.push_back(term);
		if (term != CH_CR) begin
			n = $urandom_range(0, 4);
			repeat (n) line.push_back(token_byte());
			line.push_back(CH_CR);
		end
		// broken line: drop a stop byte somewhere before the final CR
		if (kind == 1)
			line[$urandom_range(0, line.size() - 2)] = stop_byte();
		foreach (line[i]) put_byte(line[i]);
		put_byte(CH_LF);
		n = $urandom_range(0, 2);
		repeat (n) begin
			repeat ($urandom_range(1, 6)) put_byte(token_byte());
			put_eol();
		end
		put_eol();
		closed = 1'b1;
	endtask

	// Fill the byte queue, then wait for the run to drain
	initial begin : stimulus
		int unsigned random_from;
		int          heads;
		bit          closed;
		head_reset();

		// well-formed lines
		put_str("GET /index.html HTTP/1.1"); put_eol(); put_str("Host: a"); put_eol(); put_eol();
		put_str("GET  /a?b?c   HTTP/1.0"); put_eol(); put_eol();
		put_str("POST ?x V"); put_eol(); put_eol();
		// version ended by space, NUL and LF
		put_str("M /u V1 tail"); put_eol(); put_eol();
		put_str("M /u V"); put_byte(CH_NUL); put_str("z"); put_eol(); put_eol();
		put_str("M /u V"); put_byte(CH_LF); put_eol(); put_eol();
		// extreme byte values inside tokens
		put_byte(8'hFF); put_byte(8'h80); put_byte(8'h01); put_byte(CH_SP);
		put_byte(8'hFE); put_byte(CH_QM); put_byte(8'h7F); put_byte(CH_SP);
		put_byte(8'h81); put_eol(); put_eol();
		// stop bytes in method, first gap, URI and second gap
		put_str("GE"); put_byte(CH_CR); put_str("T / V"); put_eol(); put_eol();
		put_str("GET "); put_byte(CH_LF); put_str("/ V"); put_eol(); put_eol();
		put_str("GET /a"); put_byte(CH_NUL); put_str("b V"); put_eol(); put_eol();
		put_str("GET /a "); put_eol(); put_eol();
		// bare marker right after a restart, URI cut by CR
		put_eol(); put_eol();
		put_str("GET /a"); put_eol(); put_eol();
		// partial marker that resumes
		put_str("A B C"); put_eol(); put_byte(CH_CR); put_eol(); put_eol();

		// random part: a burst of minimal heads, then mostly well-formed heads
		random_from = byte_stream.size();
		repeat (12) begin
			put_str("a b c"); put_eol(); put_eol();
		end
		heads = 12;
		while (byte_stream.size() - random_from < 480 || heads < 24) begin
			put_random_head(closed);
			if (closed) heads++;
		end

		// drain
		wait (arst_n);
		while (byte_stream.size() != 0 || s_tvalid) @(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Run limit
	initial begin
		#(12 * 1000000);
		$display("TB_ERROR");
		$finish;
	end

	// Record the input handshake at the rising edge
	always @(posedge clk) begin
		byte_taken <= s_tvalid && s_tready;
	end

	// Drive bytes at the falling edge, with a random gap after each word
	always @(negedge clk) begin : drive
		logic       nv;
		logic [7:0] nd;
		nv = s_tvalid;
		nd = s_tdata;
		if (arst_n) begin
			if (s_tvalid && byte_taken) begin
				parse_byte(s_tdata);
				nv = 1'b0;
				if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
				tx_gap_left = tx_quiet ? 0 : $urandom_range(0, 11);
			end
			if (!nv) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
				end else if (byte_stream.size() > 0) begin
					nv = 1'b1;
					nd = byte_stream.pop_front();
				end
			end
			s_tvalid <= nv;
			s_tdata  <= nd;
		end
	end

	// Check each result word against the oldest expected head result
	always @(posedge clk) begin : watch
		head_result_t got;
		head_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[67:0];
			results_seen++;
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result, head_size", got.head_size, 0);
			end else begin
				want = results_due.pop_front();
				if (got.status != want.status)
					report_mismatch("status", got.status, want.status);
				if (got.head_size != want.head_size)
					report_mismatch("head_size", got.head_size, want.head_size);
				if (got.uri_start != want.uri_start)
					report_mismatch("uri_start", got.uri_start, want.uri_start);
				if (got.query_start != want.query_start)
					report_mismatch("query_start", got.query_start, want.query_start);
				if (got.version_start != want.version_start)
					report_mismatch("version_start", got.version_start, want.version_start);
				if (got.headers_start != want.headers_start)
					report_mismatch("headers_start", got.headers_start, want.headers_start);
			end
			if (m_tdata[71:68] != 4'h0)
				report_mismatch("pad bits", m_tdata[71:68], 0);
			rx_took <= 1'b1;
		end else begin
			rx_took <= 1'b0;
		end
	end

	// Drive m_tready: random wait per result, one long hold-off
	always @(negedge clk) begin : receive
		logic nr;
		nr = m_tready;
		if (arst_n) begin
			if (!held_off && results_seen >= 8) begin
				held_off   = 1'b1;
				stall_left = 600;
			end
			if (rx_took) begin
				if ($urandom_range(0, 7) == 0) rx_quiet = !rx_quiet;
				rx_wait_left = rx_quiet ? 0 : $urandom_range(0, 11);
			end
			if (stall_left > 0) begin
				stall_left--;
				nr = 1'b0;
			end else if (rx_wait_left > 0) begin
				rx_wait_left--;
				nr = 1'b0;
			end else begin
				nr = 1'b1;
			end
			m_tready <= nr;
		end
	end

endmodule
